// ===== hdl/bfs_hop_distance_macros.svh =====
// Assertion macros used by the bfs_hop_distance top level
`ifndef BFS_HOP_DISTANCE_MACROS_SVH
`define BFS_HOP_DISTANCE_MACROS_SVH

// Condition that must hold at every clock edge out of reset
`define BHD_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Condition that must hold in the cycle after the trigger
`define BHD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/bhd_pkg.sv =====
// Shared types and constants for the breadth-first hop distance block
`timescale 1ns / 1ps

package bhd_pkg;

	// width of vertex numbers, node count and hop counts
	localparam int FIELD_W = 7;

	// hop value reported for a vertex that cannot be reached
	localparam logic [FIELD_W-1:0] HOPS_UNREACHED = 7'h7F;

	// controls from the sequencer to the frontier/reach unit
	typedef struct packed {
		logic load_mask; // capture the active vertex mask for a new search
		logic acc;       // a row read was issued this cycle
		logic commit;    // close a level: new frontier, grow visited set
		logic restart;   // back to the source-only sets for the next graph
	} bhd_reach_ctl_t;

endpackage

// ===== hdl/bfs_hop_distance.sv =====
// Top level: edge loader, level-walk sequencer and result emitter
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------
//  cfg      | cfg_valid/ready    | node_count
//  in       | in_valid/in_ready  | edge_valid, end_a, end_b, last_edge
//  out      | out_valid/ready    | vertex, hops, final_res
//
// An edge word makes two row writes to the adjacency memory; a bare or
// out-of-range word writes nothing. The final word passes START, then each
// search level scans the active vertices in SCAN, reading the adjacency row
// of each frontier vertex, then DRAIN and LEVEL. A result passes distance
// read, output load and handshake; CLEAR then resets matrix and reach sets.
// Reset is asynchronous and needs no clearing pass. in_ready is low from the
// final word until the last result is taken; out_ready may stall at any time.
`timescale 1ns / 1ps

module bfs_hop_distance #(
	parameter int MAX_NODES = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [bhd_pkg::FIELD_W-1:0] node_count,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        edge_valid,
	input  logic [bhd_pkg::FIELD_W-1:0] end_a,
	input  logic [bhd_pkg::FIELD_W-1:0] end_b,
	input  logic                        last_edge,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [bhd_pkg::FIELD_W-1:0] vertex,
	output logic signed [bhd_pkg::FIELD_W-1:0] hops,
	output logic                        final_res
);

	`include "bfs_hop_distance_macros.svh"

	localparam int W  = MAX_NODES;
	localparam int AW = $clog2(MAX_NODES);
	localparam int FW = bhd_pkg::FIELD_W;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_WRB     = 4'd1;
	localparam logic [3:0] S_START   = 4'd2;
	localparam logic [3:0] S_SCAN    = 4'd3;
	localparam logic [3:0] S_DRAIN   = 4'd4;
	localparam logic [3:0] S_LEVEL   = 4'd5;
	localparam logic [3:0] S_EMIT_RD = 4'd6;
	localparam logic [3:0] S_EMIT_LD = 4'd7;
	localparam logic [3:0] S_EMIT_WT = 4'd8;
	localparam logic [3:0] S_CLEAR   = 4'd9;

	logic [3:0]    state_q;
	logic [FW-1:0] node_count_q;
	logic [AW-1:0] a_row_q;
	logic [AW-1:0] b_row_q;
	logic          last_q;
	logic [AW-1:0] scan_q;
	logic [AW-1:0] nc_last_q;
	logic [FW-1:0] lvl_q;
	logic          out_valid_q;
	logic [FW-1:0] vertex_q;
	logic [FW-1:0] hops_q;
	logic          final_q;

	logic          in_fire;
	logic          out_fire;
	logic          edge_ok;
	logic [FW-1:0] nc_eff;
	logic [AW-1:0] nc_last_d;
	logic [AW-1:0] a_row_d;
	logic [AW-1:0] b_row_d;
	logic          scan_end;

	logic          adj_wr_en;
	logic [AW-1:0] adj_wr_row;
	logic [AW-1:0] adj_wr_bit;
	logic          adj_rd_en;
	logic          adj_clr;
	logic [W-1:0]  adj_rd_data;

	logic          dist_wr_en;
	logic          dist_rd_en;
	logic [FW-1:0] dist_rd_data;

	bhd_pkg::bhd_reach_ctl_t reach_ctl;
	logic [W-1:0]  frontier;
	logic [W-1:0]  visited;
	logic          next_empty;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid_q && out_ready;

	// edge endpoints must both lie in 1..MAX_NODES
	assign edge_ok = edge_valid
		&& (end_a != '0) && (end_a <= FW'(MAX_NODES))
		&& (end_b != '0) && (end_b <= FW'(MAX_NODES));
	assign a_row_d = AW'(end_a - FW'(1));
	assign b_row_d = AW'(end_b - FW'(1));

	// node count clamped to 1..MAX_NODES
	assign nc_eff = (node_count_q == '0) ? FW'(1) :
		(node_count_q > FW'(MAX_NODES)) ? FW'(MAX_NODES) : node_count_q;
	assign nc_last_d = AW'(nc_eff - FW'(1));
	assign scan_end  = (scan_q == nc_last_q);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= FW'(1);
		end else if (cfg_valid && cfg_ready) begin
			node_count_q <= node_count;
		end
	end

	// memory and reach unit controls
	always_comb begin
		adj_wr_en  = 1'b0;
		adj_wr_row = a_row_d;
		adj_wr_bit = b_row_d;
		adj_rd_en  = 1'b0;
		adj_clr    = 1'b0;
		dist_wr_en = 1'b0;
		dist_rd_en = 1'b0;
		reach_ctl  = '0;
		case (state_q)
			S_IDLE: begin
				adj_wr_en = in_fire && edge_ok;
			end
			S_WRB: begin
				adj_wr_en  = 1'b1;
				adj_wr_row = b_row_q;
				adj_wr_bit = a_row_q;
			end
			S_START: begin
				reach_ctl.load_mask = 1'b1;
			end
			S_SCAN: begin
				// each frontier vertex: fetch its row, record its distance
				adj_rd_en     = frontier[scan_q];
				dist_wr_en    = frontier[scan_q];
				reach_ctl.acc = frontier[scan_q];
			end
			S_LEVEL: begin
				reach_ctl.commit = 1'b1;
			end
			S_EMIT_RD: begin
				dist_rd_en = 1'b1;
			end
			S_CLEAR: begin
				adj_clr           = 1'b1;
				reach_ctl.restart = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			scan_q      <= '0;
			nc_last_q   <= '0;
			lvl_q       <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						last_q <= last_edge;
						if (edge_ok) begin
							state_q <= S_WRB;
						end else if (last_edge) begin
							state_q <= S_START;
						end
					end
				end
				S_WRB: begin
					state_q <= last_q ? S_START : S_IDLE;
				end
				S_START: begin
					nc_last_q <= nc_last_d;
					scan_q    <= '0;
					lvl_q     <= '0;
					state_q   <= S_SCAN;
				end
				S_SCAN: begin
					if (scan_end) begin
						state_q <= S_DRAIN;
					end else begin
						scan_q <= scan_q + AW'(1);
					end
				end
				S_DRAIN: begin
					state_q <= S_LEVEL;
				end
				S_LEVEL: begin
					scan_q  <= '0;
					lvl_q   <= lvl_q + FW'(1);
					state_q <= next_empty ? S_EMIT_RD : S_SCAN;
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_LD;
				end
				S_EMIT_LD: begin
					out_valid_q <= 1'b1;
					state_q     <= S_EMIT_WT;
				end
				S_EMIT_WT: begin
					if (out_fire) begin
						out_valid_q <= 1'b0;
						if (scan_end) begin
							state_q <= S_CLEAR;
						end else begin
							scan_q  <= scan_q + AW'(1);
							state_q <= S_EMIT_RD;
						end
					end
				end
				S_CLEAR: begin
					last_q  <= 1'b0;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// edge endpoints held for the second row write
	always_ff @(posedge clk) begin
		if (in_fire) begin
			a_row_q <= a_row_d;
			b_row_q <= b_row_d;
		end
	end

	// output word; an unvisited vertex reports unreached
	always_ff @(posedge clk) begin
		if (state_q == S_EMIT_LD) begin
			vertex_q <= FW'(scan_q) + FW'(1);
			hops_q   <= visited[scan_q] ? dist_rd_data : bhd_pkg::HOPS_UNREACHED;
			final_q  <= scan_end;
		end
	end

	assign out_valid = out_valid_q;
	assign vertex    = vertex_q;
	assign hops      = $signed(hops_q);
	assign final_res = final_q;

	bhd_adj_mem #(
		.W  (W),
		.AW (AW)
	) u_adj (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (adj_wr_en),
		.wr_row  (adj_wr_row),
		.wr_bit  (adj_wr_bit),
		.rd_en   (adj_rd_en),
		.rd_row  (scan_q),
		.clr_all (adj_clr),
		.rd_data (adj_rd_data)
	);

	bhd_dist_mem #(
		.W  (W),
		.AW (AW)
	) u_dist (
		.clk     (clk),
		.wr_en   (dist_wr_en),
		.wr_addr (scan_q),
		.wr_data (lvl_q),
		.rd_en   (dist_rd_en),
		.rd_addr (scan_q),
		.rd_data (dist_rd_data)
	);

	bhd_reach_unit #(
		.W  (W),
		.AW (AW)
	) u_reach (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (reach_ctl),
		.row_data   (adj_rd_data),
		.nc_last    (nc_last_d),
		.frontier   (frontier),
		.visited    (visited),
		.next_empty (next_empty)
	);

	// no new word is taken while a result is pending
	`BHD_ASSERT_ALWAYS(a_no_in_while_out, !(in_ready && out_valid), "input open during emit")
	// the final result closes the run
	`BHD_ASSERT_NEXT(a_final_ends_run, out_fire && final_res, !out_valid,
		"result after final")
	// a non-final result keeps the input closed
	`BHD_ASSERT_NEXT(a_emit_holds_in, out_fire && !final_res, !in_ready,
		"input opened mid emit")
	// frontier is always inside the visited set, source always visited
	`BHD_ASSERT_ALWAYS(a_frontier_seen, ((frontier & ~visited) == '0) && visited[0],
		"frontier outside visited set")

endmodule

// ===== hdl/bhd_adj_mem.sv =====
// Adjacency bit matrix: one row per vertex, bit-enabled writes, per-row valid bits
`timescale 1ns / 1ps

module bhd_adj_mem #(
	parameter int W  = 64,
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_row,
	input  logic [AW-1:0] wr_bit,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_row,
	input  logic          clr_all,
	output logic [W-1:0]  rd_data
);

	logic [W-1:0] mem [W];
	logic [W-1:0] row_vld_q;
	logic [W-1:0] rd_data_q;
	logic         rd_vld_q;

	// row write: set one bit; a row not yet valid is rewritten whole
	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int i = 0; i < W; i++) begin
				if (wr_bit == AW'(i)) begin
					mem[wr_row][i] <= 1'b1;
				end else if (!row_vld_q[wr_row]) begin
					mem[wr_row][i] <= 1'b0;
				end
			end
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_row];
		end
	end

	// row valid bits; clearing them empties the whole matrix at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (clr_all) begin
				row_vld_q <= '0;
			end else if (wr_en) begin
				row_vld_q[wr_row] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= row_vld_q[rd_row];
			end
		end
	end

	// a row never written reads as empty
	assign rd_data = rd_data_q & {W{rd_vld_q}};

endmodule

// ===== hdl/bhd_dist_mem.sv =====
// Hop distance store: one word per vertex, one write and one registered read port
`timescale 1ns / 1ps

module bhd_dist_mem #(
	parameter int W  = 64,
	parameter int AW = 6
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [AW-1:0]               wr_addr,
	input  logic [bhd_pkg::FIELD_W-1:0] wr_data,
	input  logic                        rd_en,
	input  logic [AW-1:0]               rd_addr,
	output logic [bhd_pkg::FIELD_W-1:0] rd_data
);

	logic [bhd_pkg::FIELD_W-1:0] mem [W];
	logic [bhd_pkg::FIELD_W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/bhd_reach_unit.sv =====
// Reach unit: ORs adjacency rows, holds frontier and visited sets
`timescale 1ns / 1ps

module bhd_reach_unit #(
	parameter int W  = 64,
	parameter int AW = 6
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  bhd_pkg::bhd_reach_ctl_t ctl,
	input  logic [W-1:0]            row_data,
	input  logic [AW-1:0]           nc_last,
	output logic [W-1:0]            frontier,
	output logic [W-1:0]            visited,
	output logic                    next_empty
);

	logic [W-1:0] reach_q;
	logic [W-1:0] mask_q;
	logic [W-1:0] frontier_q;
	logic [W-1:0] visited_q;
	logic         acc_q;
	logic [W-1:0] next_set;
	logic [W-1:0] src_set;

	assign src_set  = W'(1);
	// new frontier: reached, active and not yet seen
	assign next_set = reach_q & mask_q & ~visited_q;

	// active vertex mask, taken once per search
	always_ff @(posedge clk) begin
		if (ctl.load_mask) begin
			for (int i = 0; i < W; i++) begin
				mask_q[i] <= (AW'(i) <= nc_last);
			end
		end
	end

	// accumulator and set registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reach_q    <= '0;
			frontier_q <= src_set;
			visited_q  <= src_set;
			acc_q      <= 1'b0;
		end else begin
			acc_q <= ctl.acc;
			if (ctl.restart) begin
				reach_q    <= '0;
				frontier_q <= src_set;
				visited_q  <= src_set;
			end else if (ctl.commit) begin
				reach_q    <= '0;
				frontier_q <= next_set;
				visited_q  <= visited_q | next_set;
			end else if (ctl.load_mask) begin
				reach_q <= '0;
			end else if (acc_q) begin
				// row data arrives in the cycle after its read
				reach_q <= reach_q | row_data;
			end
		end
	end

	assign frontier   = frontier_q;
	assign visited    = visited_q;
	assign next_empty = (next_set == '0);

endmodule
